@@ rtl/core/ipbw_pkg.sv @@
package ipbw_pkg;

  // image and arithmetic sizes
  localparam int SRC_WIDTH     = 512;
  localparam int SRC_HEIGHT    = 512;
  localparam int DST_SIZE      = 512;
  localparam int SUBPIXEL_BITS = 8;

  localparam int COEF_W   = 40;
  localparam int NUM_COEF = 8;
  localparam int FLD_W    = 9;
  localparam int CH_W     = 8;
  localparam int PIX_W    = 3 * CH_W;

  localparam int COL_W     = $clog2(SRC_WIDTH);
  localparam int ROW_W     = $clog2(SRC_HEIGHT);
  localparam int RH_W      = (ROW_W > 1) ? ROW_W - 1 : 1;
  localparam int MEM_AW    = RH_W + COL_W;
  localparam int MEM_DEPTH = 1 << MEM_AW;

  // divider: integer bits plus one overflow bit, then rounded fraction
  localparam int IB    = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int P_W   = COEF_W + FLD_W + 1;
  localparam int N_W   = P_W + 2;
  localparam int DS_W  = N_W + IB;
  localparam int FR_W  = SUBPIXEL_BITS + 1;
  localparam int Q_W   = IB + 1 + FR_W;
  localparam int DIV_N = Q_W;
  localparam int WT_W  = 2 * SUBPIXEL_BITS + 1;

  localparam logic signed [N_W-1:0]    W_ONE     = N_W'(32'd16777216);
  localparam logic signed [COEF_W-1:0] COEF_ONE  = COEF_W'(32'd16777216);
  localparam logic [FR_W-1:0]          SUB_ONE   = {1'b1, {SUBPIXEL_BITS{1'b0}}};

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    CFG_U_COL = 3'd0,
    CFG_U_ROW = 3'd1,
    CFG_U_OFF = 3'd2,
    CFG_V_COL = 3'd3,
    CFG_V_ROW = 3'd4,
    CFG_V_OFF = 3'd5,
    CFG_W_COL = 3'd6,
    CFG_W_ROW = 3'd7
  } cfg_idx_e;

  typedef logic signed [COEF_W-1:0] coef_t;

  typedef struct packed {
    op_e              op;
    logic [FLD_W-1:0] src_col;
    logic [FLD_W-1:0] src_row;
    logic [PIX_W-1:0] rgb;
    logic [FLD_W-1:0] dst_col;
    logic [FLD_W-1:0] dst_row;
  } item_t;

  typedef struct packed {
    op_e              op;
    logic             wr_ok;
    logic [COL_W-1:0] wcol;
    logic [ROW_W-1:0] wrow;
    logic [PIX_W-1:0] rgb;
  } hdr_t;

  typedef struct packed {
    hdr_t            hdr;
    logic            out;
    logic [N_W-1:0]  d;
    logic [DS_W-1:0] ru;
    logic [DS_W-1:0] rv;
    logic [Q_W-1:0]  qu;
    logic [Q_W-1:0]  qv;
  } div_t;

  typedef struct packed {
    hdr_t             hdr;
    logic             in_bounds;
    logic [COL_W-1:0] iu;
    logic [ROW_W-1:0] iv;
    logic [FR_W-1:0]  fx;
    logic [FR_W-1:0]  fy;
  } map_t;

  typedef struct packed {
    logic             in_bounds;
    logic [PIX_W-1:0] near;
    logic [PIX_W-1:0] blend;
  } res_t;

endpackage

@@ rtl/core/ipbw_ram.sv @@
module ipbw_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // two registered read ports, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

@@ rtl/core/ipbw_map.sv @@
module ipbw_map import ipbw_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  coef_t coef_i [NUM_COEF],
  input  logic  in_vld_i,
  output logic  in_rdy_o,
  input  item_t in_i,
  output logic  out_vld_o,
  input  logic  out_rdy_i,
  output map_t  out_o
);

  localparam int NS  = DIV_N + 4;
  localparam int DS0 = 3;

  logic [NS-1:0] vld_q;
  logic [NS-1:0] take;

  // stage advance: a stage loads when empty or when it moves on
  always_comb begin
    take[NS-1] = !vld_q[NS-1] || out_rdy_i;
    for (int k = NS - 2; k >= 0; k--) begin
      take[k] = !vld_q[k] || take[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (take[k]) begin
          vld_q[k] <= (k == 0) ? in_vld_i : vld_q[k-1];
        end
      end
    end
  end

  // stage 0: products of the coefficients with the output position
  logic signed [FLD_W:0]  col_s, row_s;
  hdr_t                   hdr0_q;
  logic                   oob0_q;
  logic signed [P_W-1:0]  puc_q, pur_q, pvc_q, pvr_q, pwc_q, pwr_q;

  assign col_s = $signed({1'b0, in_i.dst_col});
  assign row_s = $signed({1'b0, in_i.dst_row});

  always_ff @(posedge clk_i) begin
    if (take[0]) begin
      hdr0_q.op    <= in_i.op;
      hdr0_q.wr_ok <= (32'(in_i.src_col) < SRC_WIDTH) && (32'(in_i.src_row) < SRC_HEIGHT);
      hdr0_q.wcol  <= COL_W'(in_i.src_col);
      hdr0_q.wrow  <= ROW_W'(in_i.src_row);
      hdr0_q.rgb   <= in_i.rgb;
      oob0_q       <= !((32'(in_i.dst_col) < DST_SIZE) && (32'(in_i.dst_row) < DST_SIZE));
      puc_q        <= coef_i[CFG_U_COL] * col_s;
      pur_q        <= coef_i[CFG_U_ROW] * row_s;
      pvc_q        <= coef_i[CFG_V_COL] * col_s;
      pvr_q        <= coef_i[CFG_V_ROW] * row_s;
      pwc_q        <= coef_i[CFG_W_COL] * col_s;
      pwr_q        <= coef_i[CFG_W_ROW] * row_s;
    end
  end

  // stage 1: numerators and denominator
  hdr_t                  hdr1_q;
  logic                  oob1_q;
  logic signed [N_W-1:0] nu1_q, nv1_q, d1_q;

  always_ff @(posedge clk_i) begin
    if (take[1]) begin
      hdr1_q <= hdr0_q;
      oob1_q <= oob0_q;
      nu1_q  <= N_W'(puc_q) + N_W'(pur_q) + N_W'(coef_i[CFG_U_OFF]);
      nv1_q  <= N_W'(pvc_q) + N_W'(pvr_q) + N_W'(coef_i[CFG_V_OFF]);
      d1_q   <= N_W'(pwc_q) + N_W'(pwr_q) + W_ONE;
    end
  end

  // stage 2: make the denominator positive, reject zero denominators and negative quotients
  logic signed [N_W:0] nu_x, nv_x, d_x;
  logic                neg;
  hdr_t                hdr2_q;
  logic                out2_q;
  logic [N_W-1:0]      nu2_q, nv2_q, d2_q;

  always_comb begin
    neg  = d1_q[N_W-1];
    nu_x = neg ? -(N_W+1)'(nu1_q) : (N_W+1)'(nu1_q);
    nv_x = neg ? -(N_W+1)'(nv1_q) : (N_W+1)'(nv1_q);
    d_x  = neg ? -(N_W+1)'(d1_q)  : (N_W+1)'(d1_q);
  end

  always_ff @(posedge clk_i) begin
    if (take[2]) begin
      hdr2_q <= hdr1_q;
      out2_q <= oob1_q || (d1_q == '0) || nu_x[N_W] || nv_x[N_W];
      nu2_q  <= nu_x[N_W-1:0];
      nv2_q  <= nv_x[N_W-1:0];
      d2_q   <= d_x[N_W-1:0];
    end
  end

  // restoring divider, one quotient bit per stage for both axes
  div_t dv_q  [DIV_N];
  div_t dv_nx [DIV_N];

  always_comb begin
    logic [DS_W-1:0] dd, tu, tv;
    div_t            src;
    for (int j = 0; j < DIV_N; j++) begin
      if (j == 0) begin
        src.hdr = hdr2_q;
        src.out = out2_q;
        src.d   = d2_q;
        src.ru  = DS_W'(nu2_q);
        src.rv  = DS_W'(nv2_q);
        src.qu  = '0;
        src.qv  = '0;
      end else begin
        src = dv_q[j-1];
      end
      if (j <= IB) begin
        dd = DS_W'(src.d) << (IB - j);
        tu = src.ru;
        tv = src.rv;
      end else begin
        dd = DS_W'(src.d);
        tu = src.ru << 1;
        tv = src.rv << 1;
      end
      dv_nx[j]    = src;
      dv_nx[j].ru = (tu >= dd) ? tu - dd : tu;
      dv_nx[j].rv = (tv >= dd) ? tv - dd : tv;
      dv_nx[j].qu = {src.qu[Q_W-2:0], tu >= dd};
      dv_nx[j].qv = {src.qv[Q_W-2:0], tv >= dd};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < DIV_N; j++) begin
      if (take[DS0+j]) begin
        dv_q[j] <= dv_nx[j];
      end
    end
  end

  // last stage: bounds check and fraction rounding
  div_t            dl;
  logic [IB:0]     qiu, qiv;
  logic [FR_W:0]   fsu, fsv;
  logic            in_u, in_v;
  map_t            fin_q;

  always_comb begin
    dl   = dv_q[DIV_N-1];
    qiu  = dl.qu[Q_W-1:FR_W];
    qiv  = dl.qv[Q_W-1:FR_W];
    in_u = 32'(qiu) < SRC_WIDTH - 1;
    in_v = 32'(qiv) < SRC_HEIGHT - 1;
    fsu  = {1'b0, dl.qu[FR_W-1:0]} + (FR_W+1)'(1);
    fsv  = {1'b0, dl.qv[FR_W-1:0]} + (FR_W+1)'(1);
  end

  always_ff @(posedge clk_i) begin
    if (take[NS-1]) begin
      fin_q.hdr       <= dl.hdr;
      fin_q.in_bounds <= !dl.out && in_u && in_v;
      fin_q.iu        <= COL_W'(qiu);
      fin_q.iv        <= ROW_W'(qiv);
      fin_q.fx        <= fsu[FR_W:1];
      fin_q.fy        <= fsv[FR_W:1];
    end
  end

  assign in_rdy_o  = take[0];
  assign out_vld_o = vld_q[NS-1];
  assign out_o     = fin_q;

endmodule

@@ rtl/core/ipbw_blend.sv @@
module ipbw_blend import ipbw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_vld_i,
  output logic in_rdy_o,
  input  map_t in_i,
  output logic out_vld_o,
  input  logic out_rdy_i,
  output res_t out_o
);

  localparam int NS    = 4;
  localparam int PR_W  = CH_W + WT_W;
  localparam int AC_W  = PR_W + 2;
  localparam logic [AC_W-1:0] HALF = AC_W'(1) << (2 * SUBPIXEL_BITS - 1);

  logic [NS-1:0] vld_q;
  logic [NS-1:0] take;
  logic          is_query;

  assign is_query = in_i.hdr.op == OP_QUERY;

  always_comb begin
    take[NS-1] = !vld_q[NS-1] || out_rdy_i;
    for (int k = NS - 2; k >= 0; k--) begin
      take[k] = !vld_q[k] || take[k+1];
    end
  end

  // pixel writes leave the pipeline at the memory stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (take[k]) begin
          vld_q[k] <= (k == 0) ? (in_vld_i && is_query) : vld_q[k-1];
        end
      end
    end
  end

  // memory stage: even rows in one bank, odd rows in the other
  logic              wr_go, we_e, we_o;
  logic [MEM_AW-1:0] waddr, ra_e, rb_e, ra_o, rb_o;
  logic [ROW_W:0]    row_e;
  logic [COL_W-1:0]  iu1;
  logic [PIX_W-1:0]  e_a, e_b, o_a, o_b;

  always_comb begin
    wr_go = take[0] && in_vld_i && !is_query && in_i.hdr.wr_ok;
    we_e  = wr_go && !in_i.hdr.wrow[0];
    we_o  = wr_go && in_i.hdr.wrow[0];
    waddr = {RH_W'(in_i.hdr.wrow >> 1), in_i.hdr.wcol};
    row_e = (ROW_W+1)'(in_i.iv) + (ROW_W+1)'(in_i.iv[0]);
    iu1   = in_i.iu + COL_W'(1);
    ra_e  = {RH_W'(row_e >> 1), in_i.iu};
    rb_e  = {RH_W'(row_e >> 1), iu1};
    ra_o  = {RH_W'(in_i.iv >> 1), in_i.iu};
    rb_o  = {RH_W'(in_i.iv >> 1), iu1};
  end

  ipbw_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MEM_DEPTH)
  ) u_ram_even (
    .clk_i     (clk_i),
    .we_i      (we_e),
    .waddr_i   (waddr),
    .wdata_i   (in_i.hdr.rgb),
    .re_i      (take[0]),
    .raddr_a_i (ra_e),
    .raddr_b_i (rb_e),
    .rdata_a_o (e_a),
    .rdata_b_o (e_b)
  );

  ipbw_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MEM_DEPTH)
  ) u_ram_odd (
    .clk_i     (clk_i),
    .we_i      (we_o),
    .waddr_i   (waddr),
    .wdata_i   (in_i.hdr.rgb),
    .re_i      (take[0]),
    .raddr_a_i (ra_o),
    .raddr_b_i (rb_o),
    .rdata_a_o (o_a),
    .rdata_b_o (o_b)
  );

  logic            par0_q, in0_q;
  logic [FR_W-1:0] fx0_q, fy0_q;

  always_ff @(posedge clk_i) begin
    if (take[0]) begin
      par0_q <= in_i.iv[0];
      in0_q  <= in_i.in_bounds;
      fx0_q  <= in_i.fx;
      fy0_q  <= in_i.fy;
    end
  end

  // stage 1: sort the four neighbors, form the weights
  logic [FR_W-1:0]   gx, gy;
  logic [2*FR_W-1:0] m00, m01, m10, m11;
  logic [PIX_W-1:0]  p1_q [4];
  logic [WT_W-1:0]   w1_q [4];
  logic              in1_q;

  always_comb begin
    gx  = SUB_ONE - fx0_q;
    gy  = SUB_ONE - fy0_q;
    m00 = gx * gy;
    m01 = fx0_q * gy;
    m10 = gx * fy0_q;
    m11 = fx0_q * fy0_q;
  end

  always_ff @(posedge clk_i) begin
    if (take[1]) begin
      in1_q   <= in0_q;
      p1_q[0] <= par0_q ? o_a : e_a;
      p1_q[1] <= par0_q ? o_b : e_b;
      p1_q[2] <= par0_q ? e_a : o_a;
      p1_q[3] <= par0_q ? e_b : o_b;
      w1_q[0] <= m00[WT_W-1:0];
      w1_q[1] <= m01[WT_W-1:0];
      w1_q[2] <= m10[WT_W-1:0];
      w1_q[3] <= m11[WT_W-1:0];
    end
  end

  // stage 2: channel times weight
  logic [PR_W-1:0]  pr2_q [4][3];
  logic [PIX_W-1:0] near2_q;
  logic             in2_q;

  always_ff @(posedge clk_i) begin
    if (take[2]) begin
      in2_q   <= in1_q;
      near2_q <= p1_q[0];
      for (int n = 0; n < 4; n++) begin
        for (int c = 0; c < 3; c++) begin
          pr2_q[n][c] <= p1_q[n][c*CH_W +: CH_W] * w1_q[n];
        end
      end
    end
  end

  // stage 3: sum, round once, zero when outside
  logic [AC_W-1:0]  acc [3];
  logic [PIX_W-1:0] blend;
  res_t             res_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc[c] = AC_W'(pr2_q[0][c]) + AC_W'(pr2_q[1][c]) + AC_W'(pr2_q[2][c])
             + AC_W'(pr2_q[3][c]) + HALF;
      blend[c*CH_W +: CH_W] = acc[c][2*SUBPIXEL_BITS +: CH_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (take[3]) begin
      res_q.in_bounds <= in2_q;
      res_q.near      <= in2_q ? near2_q : '0;
      res_q.blend     <= in2_q ? blend : '0;
    end
  end

  assign in_rdy_o  = take[0];
  assign out_vld_o = vld_q[NS-1];
  assign out_o     = res_q;

endmodule

@@ rtl/core/inverse_perspective_bilinear_warp.sv @@
// Projective warp with bilinear resampling over a stored source image.
// Input stream: tuser selects the beat kind. A write beat stores one RGB
// source pixel and gives no result; a query beat names an output pixel and
// gives exactly one result beat, in order.
// Output stream: tuser is the inside flag; tdata carries the pixel at the
// truncated source position and the bilinear blend, all zero when outside.
// The eight coefficients must be written through the cfg port while idle;
// the block does not enforce this. Throughput: one beat per cycle unless
// stalled. A query passes the divider (one quotient bit per stage, integer
// plus fraction bits), then the source memory read and blend multiplies.
// Source memory: two banks split by row parity, each with two read ports, so
// the four neighbors are read out together.
// Reset clears the pipeline and loads the identity mapping; image content
// is undefined until written.
// A stalled receiver holds the result; input is still taken until every
// stage is full.
module inverse_perspective_bilinear_warp import ipbw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // config
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [COEF_W-1:0]   cfg_data_i,
  // input beats
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // src_col, src_row, red_in, green_in, blue_in, dst_col, dst_row, zero fill
  input  logic [63:0]         s_axis_tdata,
  // op
  input  logic                s_axis_tuser,
  // result beats
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // near_red, near_green, near_blue, blend_red, blend_green, blend_blue
  output logic [47:0]         m_axis_tdata,
  // inside_res
  output logic                m_axis_tuser
);

  // coefficient registers
  coef_t coef_q [NUM_COEF];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        coef_q[i] <= '0;
      end
      coef_q[CFG_U_COL] <= COEF_ONE;
      coef_q[CFG_V_ROW] <= COEF_ONE;
    end else if (cfg_we_i) begin
      coef_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // unpack input beat
  item_t item;

  always_comb begin
    item.op      = op_e'(s_axis_tuser);
    item.src_col = s_axis_tdata[8:0];
    item.src_row = s_axis_tdata[17:9];
    item.rgb     = {s_axis_tdata[25:18], s_axis_tdata[33:26], s_axis_tdata[41:34]};
    item.dst_col = s_axis_tdata[50:42];
    item.dst_row = s_axis_tdata[59:51];
  end

  logic map_vld, map_rdy;
  map_t map;
  res_t res;

  ipbw_map u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .coef_i    (coef_q),
    .in_vld_i  (s_axis_tvalid),
    .in_rdy_o  (s_axis_tready),
    .in_i      (item),
    .out_vld_o (map_vld),
    .out_rdy_i (map_rdy),
    .out_o     (map)
  );

  ipbw_blend u_blend (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (map_vld),
    .in_rdy_o  (map_rdy),
    .in_i      (map),
    .out_vld_o (m_axis_tvalid),
    .out_rdy_i (m_axis_tready),
    .out_o     (res)
  );

  // pack result beat
  assign m_axis_tuser = res.in_bounds;
  assign m_axis_tdata = {res.blend[7:0], res.blend[15:8], res.blend[23:16],
                         res.near[7:0], res.near[15:8], res.near[23:16]};

  // an outside result never carries pixel data
  a_outside_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("outside result with nonzero pixel data");

  // input back-pressure only when the whole pipeline is full and stalled
  a_ready_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready && map_vld && !map_rdy)
    else $error("input stalled with room in the pipeline");

  // the blend side never drops a mapped beat it has not taken
  a_map_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_vld && !map_rdy |=> map_vld)
    else $error("mapped beat lost under stall");

endmodule

@@ bench/inverse_perspective_bilinear_warp_test.sv @@
`timescale 1ns / 100ps

module inverse_perspective_bilinear_warp_test import ipbw_pkg::*; ();

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [COEF_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic m_axis_tuser;

  inverse_perspective_bilinear_warp u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  // expected result beat: tuser and tdata as on the output port
  typedef struct packed {
    logic in_bounds;
    logic [47:0] pix;
  } warp_res_t;

  // directed stimulus row
  typedef struct {
    op_e op;
    int col;
    int row;
    logic [PIX_W-1:0] rgb; // blue, green, red from the top
    bit typed;
    warp_res_t res;
  } dir_row_t;

  coef_t coef_q[NUM_COEF];
  logic [PIX_W-1:0] image_q[SRC_WIDTH*SRC_HEIGHT];
  bit written_q[SRC_WIDTH*SRC_HEIGHT];
  warp_res_t pending_res[$];

  int fails = 0;
  int cycles = 0;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("inverse_perspective_bilinear_warp_test: FAIL");
      $finish;
    end
  end

  // receiver readiness with a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req && hold_left == 0) begin
      hold_left <= HOLD_CYCLES;
      hold_req <= 1'b0;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= (hold_left == 1);
    end else begin
      m_axis_tready <= no_idle || ($urandom_range(99) >= 9);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    warp_res_t want;
    string names[6];
    names = '{"near_red", "near_green", "near_blue", "blend_red", "blend_green",
              "blend_blue"};
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_res.size() == 0) begin
        $error("result beat with nothing expected");
        fails++;
      end else begin
        want = pending_res.pop_front();
        if (want.in_bounds !== m_axis_tuser) begin
          $error("inside_res: expected %0d actual %0d", want.in_bounds, m_axis_tuser);
          fails++;
        end
        for (int k = 0; k < 6; k++)
          if (want.pix[8*k +: 8] !== m_axis_tdata[8*k +: 8]) begin
            $error("%s: expected %0d actual %0d", names[k], want.pix[8*k +: 8],
                   m_axis_tdata[8*k +: 8]);
            fails++;
          end
      end
    end
  end

  // source position of one axis: integer part and rounded fraction
  function automatic bit warp_axis(longint num, longint den, int limit,
                                   output int ip, output int fr);
    longint unsigned n, d, q, r, f;
    ip = 0;
    fr = 0;
    if (num < 0) return 1'b0;
    n = num;
    d = den;
    q = n / d;
    if (q >= longint'(limit - 1)) return 1'b0;
    r = n - q * d;
    f = 0;
    for (int i = 0; i <= SUBPIXEL_BITS; i++) begin
      r = r << 1;
      f = f << 1;
      if (r >= d) begin
        r = r - d;
        f = f | 1;
      end
    end
    ip = int'(q);
    fr = int'((f + 1) >> 1);
    return 1'b1;
  endfunction

  // mapping of an output pixel; base is the top-left neighbor address
  function automatic bit warp_map(int col, int row, output int base, output int fx,
                                  output int fy);
    longint nu, nv, d;
    int iu, iv;
    base = 0;
    fx = 0;
    fy = 0;
    nu = longint'(coef_q[CFG_U_COL]) * col + longint'(coef_q[CFG_U_ROW]) * row
       + longint'(coef_q[CFG_U_OFF]);
    nv = longint'(coef_q[CFG_V_COL]) * col + longint'(coef_q[CFG_V_ROW]) * row
       + longint'(coef_q[CFG_V_OFF]);
    d = longint'(coef_q[CFG_W_COL]) * col + longint'(coef_q[CFG_W_ROW]) * row
      + longint'(1 << 24);
    if (d == 0) return 1'b0;
    if (d < 0) begin
      d = -d;
      nu = -nu;
      nv = -nv;
    end
    if (!warp_axis(nu, d, SRC_WIDTH, iu, fx)) return 1'b0;
    if (!warp_axis(nv, d, SRC_HEIGHT, iv, fy)) return 1'b0;
    base = iv * SRC_WIDTH + iu;
    return 1'b1;
  endfunction

  function automatic warp_res_t warp_predict(int col, int row);
    warp_res_t res;
    int base, fx, fy;
    longint acc;
    logic [PIX_W-1:0] p00, p01, p10, p11;
    res = '0;
    if (!warp_map(col, row, base, fx, fy)) return res;
    p00 = image_q[base];
    p01 = image_q[base + 1];
    p10 = image_q[base + SRC_WIDTH];
    p11 = image_q[base + SRC_WIDTH + 1];
    res.in_bounds = 1'b1;
    for (int k = 0; k < 3; k++) begin
      acc = longint'(p00[8*k +: 8]) * (256 - fx) * (256 - fy)
          + longint'(p01[8*k +: 8]) * fx * (256 - fy)
          + longint'(p10[8*k +: 8]) * (256 - fx) * fy
          + longint'(p11[8*k +: 8]) * fx * fy + 32768;
      res.pix[8*k +: 8] = p00[8*k +: 8];
      res.pix[24 + 8*k +: 8] = acc[23:16];
    end
    return res;
  endfunction

  // offer one beat and wait for it to be taken
  task automatic drive_beat(op_e op, int col, int row, logic [PIX_W-1:0] rgb);
    logic [8:0] nc, nr;
    nc = $urandom;
    nr = $urandom;
    while (!no_idle && $urandom_range(99) < 9) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    if (op == OP_WRITE)
      s_axis_tdata <= {4'b0, nr, nc, rgb, 9'(row), 9'(col)};
    else
      s_axis_tdata <= {4'b0, 9'(row), 9'(col), 24'($urandom), nr, nc};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_pixel(int col, int row, logic [PIX_W-1:0] rgb);
    image_q[row * SRC_WIDTH + col] = rgb;
    written_q[row * SRC_WIDTH + col] = 1'b1;
    drive_beat(OP_WRITE, col, row, rgb);
  endtask

  // query; neighbors not yet stored are written first
  task automatic query_pixel(int col, int row, bit typed, warp_res_t res);
    int base, fx, fy, a;
    if (warp_map(col, row, base, fx, fy))
      for (int k = 0; k < 4; k++) begin
        a = base + (k & 1) + ((k >> 1) * SRC_WIDTH);
        if (!written_q[a]) write_pixel(a % SRC_WIDTH, a / SRC_WIDTH, 24'($urandom));
      end
    pending_res.push_back(typed ? res : warp_predict(col, row));
    drive_beat(OP_QUERY, col, row, '0);
  endtask

  // all coefficients written back to back while the block is idle
  task automatic load_coefs(coef_t c[NUM_COEF]);
    s_axis_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    for (int i = 0; i < NUM_COEF; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= cfg_idx_e'(i);
      cfg_data_i <= c[i];
      coef_q[i] = c[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic coef_t rand_coef();
    return coef_t'({$urandom, $urandom});
  endfunction

  // small signed value around base, spread in Q15.24
  function automatic coef_t near_coef(longint base, int spread);
    return coef_t'(base + longint'($urandom_range(2 * spread)) - spread);
  endfunction

  dir_row_t dir_rows[$];
  coef_t cfg[NUM_COEF];

  initial begin
    foreach (coef_q[i]) coef_q[i] = '0;
    coef_q[CFG_U_COL] = COEF_ONE;
    coef_q[CFG_V_ROW] = COEF_ONE;
    foreach (written_q[i]) written_q[i] = 1'b0;
    foreach (image_q[i]) image_q[i] = '0;

    // directed: identity mapping after reset, corners, extremes of the image
    dir_rows = '{
      '{OP_WRITE, 0, 0, 24'h563412, 0, '0},
      '{OP_WRITE, 1, 0, 24'h000000, 0, '0},
      '{OP_WRITE, 0, 1, 24'hffffff, 0, '0},
      '{OP_WRITE, 1, 1, 24'h808080, 0, '0},
      '{OP_QUERY, 0, 0, 24'h0, 1, '{1'b1, 48'h563412_563412}},
      '{OP_WRITE, 510, 510, 24'hffffff, 0, '0},
      '{OP_WRITE, 511, 510, 24'hffffff, 0, '0},
      '{OP_WRITE, 510, 511, 24'hffffff, 0, '0},
      '{OP_WRITE, 511, 511, 24'hffffff, 0, '0},
      '{OP_QUERY, 510, 510, 24'h0, 1, '{1'b1, 48'hffffff_ffffff}},
      '{OP_QUERY, 511, 0, 24'h0, 1, '{1'b0, 48'h0}},
      '{OP_QUERY, 0, 511, 24'h0, 1, '{1'b0, 48'h0}},
      '{OP_QUERY, 511, 511, 24'h0, 1, '{1'b0, 48'h0}},
      '{OP_QUERY, 1, 1, 24'h0, 0, '0},
      '{OP_QUERY, 510, 0, 24'h0, 0, '0}
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      if (dir_rows[i].op == OP_WRITE)
        write_pixel(dir_rows[i].col, dir_rows[i].row, dir_rows[i].rgb);
      else
        query_pixel(dir_rows[i].col, dir_rows[i].row, dir_rows[i].typed, dir_rows[i].res);

    // half-pixel steps so that the blend weights are exercised
    cfg = '{coef_t'(1 << 23), 0, coef_t'(3 << 22), 0, coef_t'(1 << 23),
            coef_t'(5 << 21), 0, 0};
    load_coefs(cfg);
    for (int c = 0; c < 4; c++) query_pixel(c, c, 0, '0);

    // denominator zero at column one
    cfg = '{COEF_ONE, 0, 0, 0, COEF_ONE, 0, -COEF_ONE, 0};
    load_coefs(cfg);
    query_pixel(1, 0, 1, '{1'b0, 48'h0});
    query_pixel(1, 7, 1, '{1'b0, 48'h0});

    // random phases, each under its own coefficient set
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: cfg = '{COEF_ONE, 0, 0, 0, COEF_ONE, 0, 0, 0};
        1: foreach (cfg[i]) cfg[i] = rand_coef();
        2: cfg = '{coef_t'({1'b0, {39{1'b1}}}), coef_t'({1'b1, 39'b0}),
                   coef_t'({1'b0, {39{1'b1}}}), coef_t'({1'b1, 39'b0}),
                   coef_t'({1'b0, {39{1'b1}}}), coef_t'({1'b1, 39'b0}),
                   coef_t'({1'b0, {39{1'b1}}}), coef_t'({1'b1, 39'b0})};
        3: cfg = '{near_coef(1 << 24, 1 << 22), near_coef(0, 1 << 22),
                   near_coef(longint'(20) << 24, 1 << 26), near_coef(0, 1 << 22),
                   near_coef(1 << 24, 1 << 22), near_coef(longint'(20) << 24, 1 << 26),
                   near_coef(0, 1 << 15), near_coef(0, 1 << 15)};
        4: cfg = '{near_coef(1 << 24, 1 << 20), 0, 0, 0, near_coef(1 << 24, 1 << 20), 0,
                   0, coef_t'(-(1 << 16))};
        5: cfg = '{coef_t'(-(1 << 24)), 0, coef_t'(longint'(511) << 24), 0,
                   coef_t'(-(1 << 24)), coef_t'(longint'(511) << 24), 0, 0};
        6: cfg = '{near_coef(1 << 23, 1 << 23), near_coef(0, 1 << 23),
                   near_coef(longint'(100) << 24, 1 << 30), near_coef(0, 1 << 23),
                   near_coef(1 << 23, 1 << 23), near_coef(longint'(100) << 24, 1 << 30),
                   near_coef(0, 1 << 16), near_coef(0, 1 << 16)};
        default: foreach (cfg[i]) cfg[i] = (i == 6 || i == 7) ?
                   coef_t'(-(1 << 24)) : rand_coef();
      endcase
      load_coefs(cfg);
      no_idle = (ph == 3);
      // queries also write their unstored neighbors, so beats outnumber steps
      for (int n = 0; n < 70; n++) begin
        if (ph == 4 && n == 20) hold_req = 1'b1;
        if ($urandom_range(99) < 30)
          write_pixel($urandom_range(511), $urandom_range(511), 24'($urandom));
        else if ($urandom_range(1))
          query_pixel($urandom_range(511), $urandom_range(511), 0, '0);
        else
          query_pixel($urandom_range(31), $urandom_range(31), 0, '0);
      end
    end
    no_idle = 1'b0;

    s_axis_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fails == 0)
      $display("inverse_perspective_bilinear_warp_test: PASS");
    else
      $display("inverse_perspective_bilinear_warp_test: FAIL");
    $finish;
  end

endmodule
